FILE: rtl/hkv_pkg.sv
`default_nettype none
package hkv_pkg;

	// Defaults for the top-level parameters.
	localparam int BUCKETS_DEF    = 256;
	localparam int WAYS_DEF       = 4;
	localparam int VALUE_BITS_DEF = 32;

	// Multiplier of the key hash: 65599 = 2^16 + 2^6 - 1.
	localparam int unsigned HASH_MULT = 65599;

	// Depth of the request queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FOUND    = 3'd2,
		ST_MISSING  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_DIV,
		BK_EXEC
	} back_state_t;

	// One finished key on its way from the front to the back.
	typedef struct packed {
		op_t         op;
		logic [31:0] hash;
		logic [31:0] value;
	} req_t;

	// h * 65599 + b, modulo 2^32, as a shift-add.
	function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
		hash_step = (h << 16) + (h << 6) - h + {24'd0, b};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/hashed_key_value_table.sv
// Hashed key/value table with a streaming key hash.
//
// Requests come in on start/busy: a request is taken at a rising edge where
// start is high and busy is low. Each request carries one key byte (has_byte
// marks it as real) and key_last ends the key. Bytes fold into a 32-bit hash,
// h = h*65599 + byte, at one per cycle while busy is low. On the request with
// key_last the hash, the operation (lookup or insert) and insert_value go into
// a two-entry queue, and the accumulator returns to zero for the next key.
// The back end reads the row of bucket hash mod BUCKETS, compares all ways,
// and an insert of a new key takes the lowest free way. A finished key
// produces one result, held on status, found_value and key_hash for
// exactly one cycle with done high. Keys without key_last produce no result.
// The back end pops the queue head and, when BUCKETS is a power of two, reads
// the bucket row at the low hash bits; otherwise the bucket index comes first
// from a multiplication by the reciprocal of BUCKETS. The compare-and-write
// follows the row read, and the result is registered. The back end takes no
// new key from the queue until it has finished the last one.
// After reset the valid bits of all buckets are cleared, one bucket per
// cycle, and busy stays high until all are cleared. The receiver cannot
// stall: results are presented once and must be taken.
`default_nettype none
module hashed_key_value_table import hkv_pkg::*; #(
	parameter int BUCKETS    = BUCKETS_DEF,
	parameter int WAYS       = WAYS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic        operation,
	input  wire logic        has_byte,
	input  wire logic [7:0]  key_byte,
	input  wire logic        key_last,
	input  wire logic [31:0] insert_value,
	output      logic        done,
	output      logic [2:0]  status,
	output      logic [31:0] found_value,
	output      logic [31:0] key_hash
);

	logic    accept;
	logic    push;
	req_t    push_req;
	logic    q_full;
	logic    head_valid;
	req_t    head_req;
	logic    pop;
	logic    clearing;
	status_t status_w;

	// Busy covers the clearing pass and a full queue; a request without
	// key_last is held by busy too, which keeps the front simple.
	assign busy   = clearing || q_full;
	assign accept = start && !busy;

	hkv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (operation),
		.has_byte     (has_byte),
		.key_byte     (key_byte),
		.key_last     (key_last),
		.insert_value (insert_value),
		.push         (push),
		.push_req     (push_req)
	);

	hkv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_req   (head_req)
	);

	hkv_back #(
		.BUCKETS    (BUCKETS),
		.WAYS       (WAYS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_req    (head_req),
		.pop         (pop),
		.clearing    (clearing),
		.done        (done),
		.status      (status_w),
		.found_value (found_value),
		.key_hash    (key_hash)
	);

	assign status = status_w;

endmodule
`default_nettype wire

FILE: rtl/hkv_front.sv
`default_nettype none
module hkv_front import hkv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        operation,
	input  wire logic        has_byte,
	input  wire logic [7:0]  key_byte,
	input  wire logic        key_last,
	input  wire logic [31:0] insert_value,
	output      logic        push,
	output      req_t        push_req
);

	logic [31:0] acc_q;
	logic [31:0] hash_d;

	assign hash_d = has_byte ? hash_step(acc_q, key_byte) : acc_q;

	// A finished key goes straight into the queue with its final hash.
	assign push           = accept && key_last;
	assign push_req.op    = op_t'(operation);
	assign push_req.hash  = hash_d;
	assign push_req.value = insert_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= key_last ? 32'd0 : hash_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/hkv_queue.sv
`default_nettype none
module hkv_queue import hkv_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire req_t push_req,
	input  wire logic pop,
	output      logic full,
	output      logic head_valid,
	output      req_t head_req
);

	req_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_req   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/hkv_back.sv
`default_nettype none
module hkv_back import hkv_pkg::*; #(
	parameter int BUCKETS    = BUCKETS_DEF,
	parameter int WAYS       = WAYS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire req_t        head_req,
	output      logic        pop,
	output      logic        clearing,
	output      logic        done,
	output      status_t     status,
	output      logic [31:0] found_value,
	output      logic [31:0] key_hash
);

	localparam int  BW       = $clog2(BUCKETS);
	localparam bit  IS_POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

	// With RECIP = ceil(2^(32+BW) / BUCKETS), (hash * RECIP) >> (32 + BW) is the
	// exact quotient for every 32-bit hash.
	localparam logic [32:0] RECIP    =
		33'(((64'd1 << (32 + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
	localparam logic [16:0] RECIP_LO = RECIP[16:0];
	localparam logic [15:0] RECIP_HI = RECIP[32:17];

	// Bucket rows: valid bits, hashes and values of all ways side by side.
	logic [WAYS-1:0]                 mem_valid [BUCKETS];
	logic [WAYS-1:0][31:0]           mem_hash  [BUCKETS];
	logic [WAYS-1:0][VALUE_BITS-1:0] mem_value [BUCKETS];

	back_state_t state_q, state_d;

	logic [BW-1:0]    clr_q;
	logic [BW-1:0]    bucket_q;
	logic [1:0]       div_cnt_q;
	logic [65:0]      prod_q;
	logic [48:0]      mul_lo;
	logic [47:0]      mul_hi;
	logic [2*BW-1:0]  qb;
	logic [BW-1:0]    rem_d;
	op_t              op_q;
	logic [31:0]      hash_q;
	logic [31:0]      value_q;

	logic [WAYS-1:0]                 vrow_q;
	logic [WAYS-1:0][31:0]           hrow_q;
	logic [WAYS-1:0][VALUE_BITS-1:0] drow_q;

	logic            rd_en;
	logic [BW-1:0]   rd_addr;
	logic            wr_en;
	logic            load;
	logic            div_init;
	logic            res_en;

	logic [WAYS-1:0]                 free_oh;
	logic                            any_free;
	logic                            any_match;
	logic [VALUE_BITS-1:0]           match_val;
	logic [WAYS-1:0][31:0]           hrow_new;
	logic [WAYS-1:0][VALUE_BITS-1:0] drow_new;
	logic [VALUE_BITS-1:0]           store_val;
	status_t                         res_status;

	logic        done_q;
	status_t     status_q;
	logic [31:0] found_q;
	logic [31:0] key_hash_q;

	// The product is built from two partial products, low half then high half;
	// the remainder then only needs the low BW bits of quotient times BUCKETS.
	assign mul_lo = hash_q * RECIP_LO;
	assign mul_hi = hash_q * RECIP_HI;
	assign qb     = prod_q[32+BW +: BW] * BW'(BUCKETS);
	assign rem_d  = hash_q[BW-1:0] - qb[BW-1:0];

	assign store_val = VALUE_BITS'(64'(value_q));

	// Way scan of the bucket row read in the previous cycle.
	always_comb begin
		logic free_taken;
		logic match_taken;
		free_oh     = '0;
		free_taken  = 1'b0;
		match_taken = 1'b0;
		match_val   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (vrow_q[w]) begin
				if (hrow_q[w] == hash_q && !match_taken) begin
					match_taken = 1'b1;
					match_val   = drow_q[w];
				end
			end else if (!free_taken) begin
				free_taken = 1'b1;
				free_oh[w] = 1'b1;
			end
			hrow_new[w] = hrow_q[w];
			drow_new[w] = drow_q[w];
		end
		for (int w = 0; w < WAYS; w++) begin
			if (free_oh[w]) begin
				hrow_new[w] = hash_q;
				drow_new[w] = store_val;
			end
		end
		any_free  = free_taken;
		any_match = match_taken;
	end

	always_comb begin
		if (op_q == OP_INSERT) begin
			if (any_match) begin
				res_status = ST_PRESENT;
			end else if (!any_free) begin
				res_status = ST_FULL;
			end else begin
				res_status = ST_INSERTED;
			end
		end else begin
			res_status = any_match ? ST_FOUND : ST_MISSING;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load     = 1'b0;
		div_init = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = head_req.hash[BW-1:0];
		wr_en    = 1'b0;
		res_en   = 1'b0;
		clearing = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				clearing = 1'b1;
				if (clr_q == BW'(BUCKETS - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (head_valid) begin
					pop  = 1'b1;
					load = 1'b1;
					if (IS_POW2) begin
						rd_en   = 1'b1;
						state_d = BK_EXEC;
					end else begin
						div_init = 1'b1;
						state_d  = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (div_cnt_q == 2'd2) begin
					rd_en   = 1'b1;
					rd_addr = rem_d;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				res_en  = 1'b1;
				wr_en   = (op_q == OP_INSERT) && !any_match && any_free;
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_en;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q    <= head_req.op;
			hash_q  <= head_req.hash;
			value_q <= head_req.value;
		end
		if (div_init) begin
			div_cnt_q <= 2'd0;
		end else if (state_q == BK_DIV) begin
			div_cnt_q <= div_cnt_q + 2'd1;
			if (div_cnt_q == 2'd0) begin
				prod_q <= 66'(mul_lo);
			end else if (div_cnt_q == 2'd1) begin
				prod_q <= prod_q + 66'({mul_hi, 17'd0});
			end
		end
		if (rd_en) begin
			bucket_q <= rd_addr;
		end
		if (res_en) begin
			status_q   <= res_status;
			found_q    <= (res_status == ST_FOUND) ? 32'(64'(match_val)) : 32'd0;
			key_hash_q <= hash_q;
		end
	end

	// Bucket memory: one row read or written per cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			vrow_q <= mem_valid[rd_addr];
			hrow_q <= mem_hash[rd_addr];
			drow_q <= mem_value[rd_addr];
		end
		if (clearing) begin
			mem_valid[clr_q] <= '0;
		end else if (wr_en) begin
			mem_valid[bucket_q] <= vrow_q | free_oh;
			mem_hash[bucket_q]  <= hrow_new;
			mem_value[bucket_q] <= drow_new;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign key_hash    = key_hash_q;

endmodule
`default_nettype wire

FILE: rtl/hkv_checker.sv
`default_nettype none
module hkv_checker import hkv_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [2:0]  status,
	input wire logic [31:0] found_value
);

	// Every key passes through a bucket read and an execute step in the back end.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// Only a successful lookup returns a value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_FOUND) |-> (found_value == 32'd0))
		else $error("found_value nonzero without a hit");

	// The table clear keeps the block busy right after reset.
	a_busy_after_reset: assert property (@(posedge clk)
		(!$past(arst_n) && arst_n) |-> busy)
		else $error("not busy during the clearing pass");

	// No result can come out of the clearing pass.
	a_no_done_after_reset: assert property (@(posedge clk)
		(!$past(arst_n) && arst_n) |-> !done)
		else $error("result right after reset");

endmodule

bind hashed_key_value_table hkv_checker u_hkv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.found_value (found_value)
);
`default_nettype wire
